[rtl/imhq_pkg.sv]
// types and constants shared by the indexed min-heap queue
package imhq_pkg;

  localparam int KEY_W = 6;
  localparam int PRIO_W = 32;
  localparam int CNT_W = 7;
  localparam int STAT_W = 3;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_CHANGE  = 2'd2,
    REQ_DELETE  = 2'd3
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [KEY_W-1:0]  item_key;
    logic signed [PRIO_W-1:0] item_priority;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [KEY_W-1:0]  out_key;
    logic signed [PRIO_W-1:0] out_priority;
    logic              min_valid;
    logic [CNT_W-1:0]  entry_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_POS,
    S_WAIT_POS,
    S_DECIDE,
    S_RD_LAST,
    S_WAIT_LAST,
    S_PLACE,
    S_UP_CMP,
    S_DN_RD,
    S_DN_WAIT,
    S_DN_CMP,
    S_RD_ROOT,
    S_WAIT_ROOT,
    S_DONE
  } state_t;

endpackage

[rtl/imhq_ram.sv]
// generic single-write dual-read ram with registered read data
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/indexed_min_heap_queue.sv]
// top level of the indexed min-heap queue
// Indexed binary min-heap of up to HEAP_DEPTH (key, priority) entries with a
// per-key position table, serving insert, extract-minimum, change-priority
// and delete-by-key requests, one at a time. A request is taken only while
// in_ready is high; it then walks the heap with a single shared compare unit
// over a dual-read slot memory: a setup that reads the key's position and
// the root and decides, a sift up that compares with the parent per level,
// a sift down that reads both children and compares per level, and a read of
// the root to build the result (log2 of HEAP_DEPTH levels bound the walk).
// The result is held in an output register until taken; the next request is
// accepted the cycle after that.
// Presence bits of the keys clear at reset, so no clearing pass is needed.
module indexed_min_heap_queue #(
  parameter int HEAP_DEPTH = 64,
  parameter int KEY_COUNT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  imhq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output imhq_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);
  import imhq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int KW = $clog2(KEY_COUNT);
  localparam int FW = $clog2(HEAP_DEPTH + 1);
  localparam int SW = PRIO_W + KW;

  // configuration register
  logic [CNT_W-1:0] cap_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(64);
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // slot ram: {priority, key}
  logic          s_we;
  logic [AW-1:0] s_waddr, s_ra, s_rb;
  logic [SW-1:0] s_wdata, s_da, s_db;
  imhq_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr_a(s_ra), .rdata_a(s_da), .raddr_b(s_rb), .rdata_b(s_db)
  );

  // position ram, presence bits in flops
  logic          p_we;
  logic [KW-1:0] p_waddr, p_ra;
  logic [AW-1:0] p_wdata, p_da, p_unused;
  imhq_ram #(.WIDTH(AW), .DEPTH(KEY_COUNT)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr_a(p_ra), .rdata_a(p_da), .raddr_b(p_ra), .rdata_b(p_unused)
  );
  logic [KEY_COUNT-1:0] present_r, present_nxt;

  state_t state_r, state_nxt;
  in_item_t req_r, req_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] idx_r, idx_nxt;          // current slot of the moving entry
  logic [SW-1:0] cur_r, cur_nxt;          // moving entry
  logic [SW-1:0] lc_r, lc_nxt;            // lesser child held during sift down
  logic [AW-1:0] lidx_r, lidx_nxt;
  logic          taken_r, taken_nxt;
  logic [SW-1:0] tk_r, tk_nxt;
  status_t       st_r, st_nxt;
  logic          ov_r, ov_nxt;
  out_item_t     ob_r, ob_nxt;

  logic key_ok;
  logic [FW-1:0] cap_eff;
  assign key_ok = ({{(32-KEY_W){1'b0}}, req_r.item_key} < KEY_COUNT);
  assign cap_eff = ({{(32-CNT_W){1'b0}}, cap_r} > 32'(HEAP_DEPTH)) ?
                   FW'(HEAP_DEPTH) : FW'(cap_r);

  // shared compare unit: a strictly below b
  logic [SW-1:0] cmp_a, cmp_b;
  logic lt;
  assign lt = $signed(cmp_a[SW-1:KW]) < $signed(cmp_b[SW-1:KW]);

  // parent and child slots of the moving entry
  logic [AW-1:0] parent, left, right;
  logic [AW+1:0] lt_w, rt_w, fill_w;
  assign parent = (idx_r - AW'(1)) >> 1;
  assign lt_w   = {1'b0, idx_r, 1'b1};
  assign rt_w   = lt_w + (AW+2)'(1);
  assign fill_w = (AW+2)'(fill_r);
  assign left   = lt_w[AW-1:0];
  assign right  = rt_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      present_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      present_r <= present_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; idx_r <= idx_nxt; cur_r <= cur_nxt; lc_r <= lc_nxt;
    lidx_r <= lidx_nxt; taken_r <= taken_nxt; tk_r <= tk_nxt; st_r <= st_nxt;
    ob_r <= ob_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; req_nxt = req_r; fill_nxt = fill_r; idx_nxt = idx_r;
    cur_nxt = cur_r; lc_nxt = lc_r; lidx_nxt = lidx_r; taken_nxt = taken_r;
    tk_nxt = tk_r; st_nxt = st_r; ov_nxt = ov_r; ob_nxt = ob_r;
    present_nxt = present_r;
    s_we = 1'b0; s_waddr = idx_r; s_wdata = cur_r; s_ra = '0; s_rb = '0;
    p_we = 1'b0; p_waddr = cur_r[KW-1:0]; p_wdata = idx_r; p_ra = req_r.item_key[KW-1:0];
    cmp_a = cur_r; cmp_b = s_da;
    in_ready = (state_r == S_IDLE) && !ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt = in_item; taken_nxt = 1'b0; st_nxt = ST_OK;
          state_nxt = S_RD_POS;
        end
      end
      S_RD_POS: begin
        s_ra = '0;
        state_nxt = S_WAIT_POS;
      end
      S_WAIT_POS: state_nxt = S_DECIDE;
      S_DECIDE: begin
        state_nxt = S_RD_ROOT;
        if (req_r.req_type == REQ_EXTRACT) begin
          if (fill_r == '0) st_nxt = ST_EMPTY;
          else begin
            taken_nxt = 1'b1; tk_nxt = s_da; idx_nxt = '0;
            present_nxt[s_da[KW-1:0]] = 1'b0;
            state_nxt = S_RD_LAST;
          end
        end else if (!key_ok) begin
          st_nxt = ST_ABSENT;
        end else if (req_r.req_type == REQ_INSERT) begin
          if (fill_r >= cap_eff) st_nxt = ST_FULL;
          else if (present_r[req_r.item_key[KW-1:0]]) st_nxt = ST_PRESENT;
          else begin
            present_nxt[req_r.item_key[KW-1:0]] = 1'b1;
            idx_nxt = fill_r[AW-1:0];
            cur_nxt = {req_r.item_priority, req_r.item_key[KW-1:0]};
            fill_nxt = fill_r + FW'(1);
            state_nxt = S_PLACE;
          end
        end else if (!present_r[req_r.item_key[KW-1:0]] || FW'(p_da) >= fill_r) begin
          st_nxt = ST_ABSENT;
        end else if (req_r.req_type == REQ_CHANGE) begin
          idx_nxt = p_da;
          cur_nxt = {req_r.item_priority, req_r.item_key[KW-1:0]};
          state_nxt = S_PLACE;
        end else begin
          idx_nxt = p_da;
          present_nxt[req_r.item_key[KW-1:0]] = 1'b0;
          state_nxt = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        s_ra = AW'(fill_r - FW'(1));
        fill_nxt = fill_r - FW'(1);
        state_nxt = S_WAIT_LAST;
      end
      S_WAIT_LAST: begin
        cur_nxt = s_da;
        state_nxt = (FW'(idx_r) < fill_r) ? S_PLACE : S_RD_ROOT;
      end
      S_PLACE: begin
        // write moving entry at idx and its position, then sift up, or sift down at the root
        s_we = 1'b1; p_we = 1'b1;
        s_ra = parent;
        state_nxt = (idx_r == '0) ? S_DN_RD : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmp_a = cur_r; cmp_b = s_da;
        if (lt) begin
          // parent moves down into idx, moving entry into parent
          s_we = 1'b1; s_wdata = s_da;
          p_we = 1'b1; p_waddr = s_da[KW-1:0]; p_wdata = idx_r;
          idx_nxt = parent;
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_DN_RD: begin
        // moving entry lands at idx, children are read
        s_we = 1'b1; p_we = 1'b1;
        s_ra = left; s_rb = right;
        if (lt_w >= fill_w) state_nxt = S_RD_ROOT;
        else state_nxt = S_DN_WAIT;
      end
      S_DN_WAIT: begin
        // pick the lesser child, left on ties
        cmp_a = s_db; cmp_b = s_da;
        if (rt_w < fill_w && lt) begin
          lc_nxt = s_db; lidx_nxt = right;
        end else begin
          lc_nxt = s_da; lidx_nxt = left;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmp_a = lc_r; cmp_b = cur_r;
        if (lt) begin
          // child moves up into idx, moving entry goes one level down
          s_we = 1'b1; s_wdata = lc_r;
          p_we = 1'b1; p_waddr = lc_r[KW-1:0]; p_wdata = idx_r;
          idx_nxt = lidx_r;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_RD_ROOT;
        end
      end
      S_RD_ROOT: begin
        s_ra = '0;
        state_nxt = S_WAIT_ROOT;
      end
      S_WAIT_ROOT: state_nxt = S_DONE;
      S_DONE: begin
        // build result
        ob_nxt.status = st_r;
        ob_nxt.entry_count = CNT_W'(fill_r);
        if (taken_r) begin
          ob_nxt.out_key = KEY_W'(tk_r[KW-1:0]);
          ob_nxt.out_priority = tk_r[SW-1:KW];
          ob_nxt.min_valid = 1'b1;
        end else if (fill_r != '0) begin
          ob_nxt.out_key = KEY_W'(s_da[KW-1:0]);
          ob_nxt.out_priority = s_da[SW-1:KW];
          ob_nxt.min_valid = 1'b1;
        end else begin
          ob_nxt.out_key = '0;
          ob_nxt.out_priority = '0;
          ob_nxt.min_valid = 1'b0;
        end
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_item = ob_r;

endmodule
